FILE: hdl/upa_pkg.sv
// Shared types, constants and saturation helpers for the uncertainty propagation ALU.
package upa_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int UNC_W       = DATA_W - 1;
    localparam int Q_DEPTH_DEF = 2;

    localparam int D1_NW = 2 * DATA_W - 1;
    localparam int D2_NW = UNC_W + FRAC_W;
    localparam int SQ_RW = 2 * DATA_W;

    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [UNC_W-1:0]  UNC_MAX = {UNC_W{1'b1}};

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CNT  = 3'd4,
        OP_SQRT = 3'd5,
        OP_NEG  = 3'd6,
        OP_PASS = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SQRT = 2'd2,
        ST_SAT  = 2'd3
    } st_t;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] a_value;
        logic [UNC_W-1:0]         a_unc;
        logic signed [DATA_W-1:0] b_value;
        logic [UNC_W-1:0]         b_unc;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] r_value;
        logic [UNC_W-1:0]         r_unc;
        st_t                      status;
    } out_t;

    typedef struct packed {
        op_t                      op;
        st_t                      st;
        logic                     sat;
        logic                     neg;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] rv;
        logic [DATA_W-1:0]        ma;
        logic [DATA_W-1:0]        mb;
        logic [UNC_W-1:0]         au;
        logic [UNC_W-1:0]         bu;
        logic [UNC_W-1:0]         ru;
        logic [UNC_W-1:0]         lx;
        logic [UNC_W-1:0]         ly;
        logic                     lsat;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    typedef struct packed {
        logic signed [DATA_W-1:0] v;
        logic                     sat;
    } sv_t;

    // Magnitude plus sign into a saturated signed value.
    function automatic sv_t sat_mag(input logic [D1_NW-1:0] q, input logic neg);
        sv_t r;
        r.sat = 1'b0;
        if (!neg) begin
            if (q > D1_NW'(VAL_MAX)) begin
                r.v   = VAL_MAX;
                r.sat = 1'b1;
            end else begin
                r.v = q[DATA_W-1:0];
            end
        end else begin
            if (q > D1_NW'(VAL_MIN)) begin
                r.v   = VAL_MIN;
                r.sat = 1'b1;
            end else begin
                r.v = DATA_W'(0) - q[DATA_W-1:0];
            end
        end
        return r;
    endfunction

    // Signed value one bit wider than DATA_W, saturated into range.
    function automatic sv_t sat_wide(input logic [DATA_W:0] x);
        sv_t r;
        r.sat = x[DATA_W] ^ x[DATA_W-1];
        r.v   = r.sat ? (x[DATA_W] ? VAL_MIN : VAL_MAX) : x[DATA_W-1:0];
        return r;
    endfunction

endpackage

FILE: hdl/upa_front.sv
// Front end: takes a transaction, decodes the opcode and settles the simple cases.
module upa_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  upa_pkg::in_t  operands,
    output logic          valid,
    output upa_pkg::job_t item
);
    import upa_pkg::*;

    logic              valid_reg;
    job_t              item_reg;
    job_t              item_next;
    logic [DATA_W-1:0] a_bits;
    logic [DATA_W-1:0] b_bits;
    sv_t               add_s;
    sv_t               sub_s;
    sv_t               neg_s;

    assign a_bits = operands.a_value;
    assign b_bits = operands.b_value;
    assign add_s  = sat_wide({a_bits[DATA_W-1], a_bits} + {b_bits[DATA_W-1], b_bits});
    assign sub_s  = sat_wide({a_bits[DATA_W-1], a_bits} - {b_bits[DATA_W-1], b_bits});
    assign neg_s  = sat_wide((DATA_W+1)'(0) - {a_bits[DATA_W-1], a_bits});

    always_comb
    begin
        item_next      = '0;
        item_next.op   = op_t'(operands.opcode);
        item_next.st   = ST_OK;
        item_next.a    = operands.a_value;
        item_next.au   = operands.a_unc;
        item_next.bu   = operands.b_unc;
        item_next.ma   = a_bits[DATA_W-1] ? DATA_W'(0) - a_bits : a_bits;
        item_next.mb   = b_bits[DATA_W-1] ? DATA_W'(0) - b_bits : b_bits;
        item_next.neg  = a_bits[DATA_W-1] ^ b_bits[DATA_W-1];
        unique case (item_next.op)
            OP_ADD:
            begin
                item_next.rv  = add_s.v;
                item_next.sat = add_s.sat;
            end
            OP_SUB:
            begin
                item_next.rv  = sub_s.v;
                item_next.sat = sub_s.sat;
            end
            OP_MUL: ;
            OP_DIV:
            begin
                if (b_bits == '0)
                    item_next.st = ST_DIV0;
            end
            OP_CNT:
            begin
                item_next.rv = operands.a_value;
                if (a_bits[DATA_W-1])
                    item_next.st = ST_SQRT;
            end
            OP_SQRT:
            begin
                if (a_bits[DATA_W-1] || a_bits == '0)
                    item_next.st = ST_SQRT;
            end
            OP_NEG:
            begin
                item_next.rv  = neg_s.v;
                item_next.sat = neg_s.sat;
                item_next.ru  = operands.a_unc;
            end
            OP_PASS:
            begin
                item_next.rv = operands.a_value;
                item_next.ru = operands.a_unc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

FILE: hdl/upa_queue.sv
// Short queue between the front end and the execution back end.
module upa_queue #(
    parameter int DEPTH = upa_pkg::Q_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  upa_pkg::job_t push_item,
    input  logic          pop,
    output logic          valid,
    output upa_pkg::job_t item,
    output logic          full
);
    import upa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign do_push = push && (count_reg != CNT_W'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign valid = (count_reg != '0);
    assign item  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));

endmodule

FILE: hdl/upa_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
module upa_div #(
    parameter int NW    = upa_pkg::D1_NW,
    parameter int DW    = upa_pkg::DATA_W,
    parameter int LANES = 1,
    parameter int PW    = upa_pkg::JOB_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [LANES-1:0][NW-1:0]  in_num,
    input  logic [DW-1:0]             in_den,
    input  logic [PW-1:0]             in_side,
    output logic                      out_valid,
    output logic [LANES-1:0][NW-1:0]  out_quo,
    output logic [PW-1:0]             out_side
);
    logic                     v_reg    [NW];
    logic [LANES-1:0][DW-1:0] rem_reg  [NW];
    logic [LANES-1:0][NW-1:0] num_reg  [NW];
    logic [DW-1:0]            den_reg  [NW];
    logic [PW-1:0]            side_reg [NW];

    genvar s;
    generate
        for (s = 0; s < NW; s++)
        begin : g_stage
            logic                     v_prev;
            logic [LANES-1:0][DW-1:0] rem_prev;
            logic [LANES-1:0][DW-1:0] rem_next;
            logic [LANES-1:0][NW-1:0] num_prev;
            logic [LANES-1:0][NW-1:0] num_next;
            logic [DW-1:0]            den_prev;
            logic [PW-1:0]            side_prev;
            logic [DW:0]              trial;

            if (s == 0)
            begin : g_first
                assign v_prev    = in_valid;
                assign rem_prev  = '0;
                assign num_prev  = in_num;
                assign den_prev  = in_den;
                assign side_prev = in_side;
            end
            else
            begin : g_rest
                assign v_prev    = v_reg[s-1];
                assign rem_prev  = rem_reg[s-1];
                assign num_prev  = num_reg[s-1];
                assign den_prev  = den_reg[s-1];
                assign side_prev = side_reg[s-1];
            end

            always_comb
            begin
                trial    = '0;
                rem_next = '0;
                num_next = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    trial = {rem_prev[l], num_prev[l][NW-1]};
                    if (trial >= {1'b0, den_prev})
                    begin
                        rem_next[l] = DW'(trial - {1'b0, den_prev});
                        num_next[l] = {num_prev[l][NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = trial[DW-1:0];
                        num_next[l] = {num_prev[l][NW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else
                    v_reg[s] <= v_prev;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s]  <= rem_next;
                num_reg[s]  <= num_next;
                den_reg[s]  <= den_prev;
                side_reg[s] <= side_prev;
            end
        end
    endgenerate

    assign out_valid = v_reg[NW-1];
    assign out_quo   = num_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

FILE: hdl/upa_sqrt.sv
// Pipelined integer square root, two radicand bits per stage, floor result.
module upa_sqrt #(
    parameter int RW = upa_pkg::SQ_RW,
    parameter int PW = upa_pkg::JOB_W
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [RW-1:0]   in_rad,
    input  logic [PW-1:0]   in_side,
    output logic            out_valid,
    output logic [RW/2-1:0] out_root,
    output logic [PW-1:0]   out_side
);
    localparam int NS  = RW / 2;
    localparam int RMW = NS + 2;

    logic           v_reg    [NS];
    logic [RMW-1:0] rem_reg  [NS];
    logic [NS-1:0]  root_reg [NS];
    logic [RW-1:0]  rad_reg  [NS];
    logic [PW-1:0]  side_reg [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            logic           v_prev;
            logic [RMW-1:0] rem_prev;
            logic [RMW-1:0] rem_next;
            logic [NS-1:0]  root_prev;
            logic [NS-1:0]  root_next;
            logic [RW-1:0]  rad_prev;
            logic [PW-1:0]  side_prev;
            logic [RMW+1:0] t;
            logic [RMW+1:0] trial;

            if (s == 0)
            begin : g_first
                assign v_prev    = in_valid;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign rad_prev  = in_rad;
                assign side_prev = in_side;
            end
            else
            begin : g_rest
                assign v_prev    = v_reg[s-1];
                assign rem_prev  = rem_reg[s-1];
                assign root_prev = root_reg[s-1];
                assign rad_prev  = rad_reg[s-1];
                assign side_prev = side_reg[s-1];
            end

            assign t     = {rem_prev, rad_prev[RW-1 -: 2]};
            assign trial = (RMW+2)'({root_prev, 2'b01});

            always_comb
            begin
                if (t >= trial)
                begin
                    rem_next  = RMW'(t - trial);
                    root_next = {root_prev[NS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = t[RMW-1:0];
                    root_next = {root_prev[NS-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else
                    v_reg[s] <= v_prev;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                rad_reg[s]  <= {rad_prev[RW-3:0], 2'b00};
                side_reg[s] <= side_prev;
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

FILE: hdl/upa_back.sv
// Back end: multiply, divide, quadrature root and final saturation pipeline.
module upa_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  upa_pkg::job_t item,
    output logic          done,
    output upa_pkg::out_t result
);
    import upa_pkg::*;

    // multiply stage
    logic                  b1_v_reg;
    job_t                  b1_job_reg;
    logic [2*DATA_W-1:0]   b1_p_reg;
    logic [D1_NW-1:0]      b1_px_reg;
    logic [D1_NW-1:0]      b1_py_reg;
    logic [2*DATA_W-1:0]   p_c;
    logic [D1_NW-1:0]      px_c;
    logic [D1_NW-1:0]      py_c;

    // product rounding, first divider setup
    logic [2*DATA_W-1:0]   mq_c;
    sv_t                   ms_c;
    logic [D1_NW-1:0]      mx_c;
    logic [D1_NW-1:0]      my_c;
    job_t                  j2_c;
    logic [1:0][D1_NW-1:0] n2_c;
    logic                  b2_v_reg;
    job_t                  b2_job_reg;
    logic [1:0][D1_NW-1:0] b2_num_reg;

    logic                  d1_v;
    logic [1:0][D1_NW-1:0] d1_quo;
    logic [JOB_W-1:0]      d1_side;

    // quotient handling, hypot legs
    job_t                  d1_job;
    job_t                  j3_c;
    sv_t                   ds_c;
    logic                  b3_v_reg;
    job_t                  b3_job_reg;

    // squares
    logic                  b4_v_reg;
    job_t                  b4_job_reg;
    logic [2*UNC_W-1:0]    b4_sx_reg;
    logic [2*UNC_W-1:0]    b4_sy_reg;

    // radicand select
    logic [SQ_RW-1:0]      rad_c;
    logic                  b5_v_reg;
    job_t                  b5_job_reg;
    logic [SQ_RW-1:0]      b5_rad_reg;

    logic                  sq_v;
    logic [SQ_RW/2-1:0]    sq_root;
    logic [JOB_W-1:0]      sq_side;

    // root handling, second divider setup
    job_t                  sq_job;
    job_t                  j6_c;
    logic                  hsat_c;
    logic [UNC_W-1:0]      hyp_c;
    logic [D2_NW-1:0]      n6_c;
    logic [DATA_W-1:0]     den6_c;
    logic                  b6_v_reg;
    job_t                  b6_job_reg;
    logic [D2_NW-1:0]      b6_num_reg;
    logic [DATA_W-1:0]     b6_den_reg;

    logic                  d2_v;
    logic [D2_NW-1:0]      d2_quo;
    logic [JOB_W-1:0]      d2_side;

    // final
    job_t                  j7_c;
    out_t                  res_c;
    logic                  done_reg;
    out_t                  result_reg;

    assign p_c  = item.ma * item.mb;
    assign px_c = item.mb * item.au;
    assign py_c = item.ma * item.bu;

    always_ff @(posedge clk)
    begin
        b1_job_reg <= item;
        b1_p_reg   <= p_c;
        b1_px_reg  <= px_c;
        b1_py_reg  <= py_c;
    end

    assign mq_c = (b1_p_reg + (2*DATA_W)'(1 << (FRAC_W - 1))) >> FRAC_W;
    assign ms_c = sat_mag(D1_NW'(mq_c), b1_job_reg.neg);
    assign mx_c = b1_px_reg >> FRAC_W;
    assign my_c = b1_py_reg >> FRAC_W;

    always_comb
    begin
        j2_c = b1_job_reg;
        unique case (b1_job_reg.op)
            OP_ADD, OP_SUB:
            begin
                j2_c.lx = b1_job_reg.au;
                j2_c.ly = b1_job_reg.bu;
            end
            OP_MUL:
            begin
                j2_c.rv   = ms_c.v;
                j2_c.sat  = ms_c.sat;
                j2_c.lx   = mx_c[UNC_W-1:0];
                j2_c.ly   = my_c[UNC_W-1:0];
                j2_c.lsat = (mx_c > D1_NW'(UNC_MAX)) || (my_c > D1_NW'(UNC_MAX));
            end
            default: ;
        endcase
        n2_c[0] = b1_py_reg;
        n2_c[1] = D1_NW'({b1_job_reg.ma, FRAC_W'(0)}) + D1_NW'(b1_job_reg.mb >> 1);
    end

    always_ff @(posedge clk)
    begin
        b2_job_reg <= j2_c;
        b2_num_reg <= n2_c;
    end

    upa_div #(
        .NW    (D1_NW),
        .DW    (DATA_W),
        .LANES (2),
        .PW    (JOB_W)
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b2_v_reg),
        .in_num    (b2_num_reg),
        .in_den    (b2_job_reg.mb),
        .in_side   (b2_job_reg),
        .out_valid (d1_v),
        .out_quo   (d1_quo),
        .out_side  (d1_side)
    );

    assign d1_job = job_t'(d1_side);
    assign ds_c   = sat_mag(d1_quo[1], d1_job.neg);

    always_comb
    begin
        j3_c = d1_job;
        if (j3_c.op == OP_DIV)
        begin
            j3_c.rv   = ds_c.v;
            j3_c.sat  = ds_c.sat;
            j3_c.lx   = j3_c.au;
            j3_c.ly   = d1_quo[0][UNC_W-1:0];
            j3_c.lsat = d1_quo[0] > D1_NW'(UNC_MAX);
        end
    end

    always_ff @(posedge clk)
    begin
        b3_job_reg <= j3_c;
        b4_job_reg <= b3_job_reg;
        b4_sx_reg  <= b3_job_reg.lx * b3_job_reg.lx;
        b4_sy_reg  <= b3_job_reg.ly * b3_job_reg.ly;
    end

    assign rad_c = (b4_job_reg.op == OP_CNT || b4_job_reg.op == OP_SQRT)
                 ? SQ_RW'({b4_job_reg.a[UNC_W-1:0], FRAC_W'(0)})
                 : SQ_RW'(b4_sx_reg) + SQ_RW'(b4_sy_reg);

    always_ff @(posedge clk)
    begin
        b5_job_reg <= b4_job_reg;
        b5_rad_reg <= rad_c;
    end

    upa_sqrt #(
        .RW (SQ_RW),
        .PW (JOB_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b5_v_reg),
        .in_rad    (b5_rad_reg),
        .in_side   (b5_job_reg),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_job = job_t'(sq_side);
    assign hsat_c = sq_job.lsat || sq_root[DATA_W-1];
    assign hyp_c  = hsat_c ? UNC_MAX : sq_root[UNC_W-1:0];

    always_comb
    begin
        j6_c   = sq_job;
        n6_c   = {hyp_c, FRAC_W'(0)};
        den6_c = j6_c.mb;
        unique case (j6_c.op)
            OP_ADD, OP_SUB, OP_MUL, OP_CNT:
            begin
                j6_c.ru  = hyp_c;
                j6_c.sat = j6_c.sat | hsat_c;
            end
            OP_DIV:
            begin
                j6_c.sat = j6_c.sat | hsat_c;
            end
            OP_SQRT:
            begin
                j6_c.rv = sq_root;
                n6_c    = {j6_c.au, FRAC_W'(0)};
                den6_c  = {sq_root[DATA_W-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        b6_job_reg <= j6_c;
        b6_num_reg <= n6_c;
        b6_den_reg <= den6_c;
    end

    upa_div #(
        .NW    (D2_NW),
        .DW    (DATA_W),
        .LANES (1),
        .PW    (JOB_W)
    ) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b6_v_reg),
        .in_num    (b6_num_reg),
        .in_den    (b6_den_reg),
        .in_side   (b6_job_reg),
        .out_valid (d2_v),
        .out_quo   (d2_quo),
        .out_side  (d2_side)
    );

    always_comb
    begin
        j7_c = job_t'(d2_side);
        if (j7_c.op == OP_DIV || j7_c.op == OP_SQRT)
        begin
            if (d2_quo > D2_NW'(UNC_MAX))
            begin
                j7_c.ru  = UNC_MAX;
                j7_c.sat = 1'b1;
            end
            else
            begin
                j7_c.ru = d2_quo[UNC_W-1:0];
            end
        end
        if (j7_c.st != ST_OK)
        begin
            res_c.r_value = '0;
            res_c.r_unc   = '0;
            res_c.status  = j7_c.st;
        end
        else
        begin
            res_c.r_value = j7_c.rv;
            res_c.r_unc   = j7_c.ru;
            res_c.status  = j7_c.sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
            b5_v_reg <= 1'b0;
            b6_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            b1_v_reg <= in_valid;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= d1_v;
            b4_v_reg <= b3_v_reg;
            b5_v_reg <= b4_v_reg;
            b6_v_reg <= sq_v;
            done_reg <= d2_v;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/uncertainty_propagation_alu_top.sv
// Top level of the uncertainty propagation ALU: front end, queue and execution pipeline.
// Throughput: one transaction per cycle; the 63-stage and 47-stage divider pipelines and
// the 32-stage root pipeline each take a new item every cycle.
// busy reflects a full queue; the receiver cannot stall, so it never rises in practice.
// Reset: rst_n asynchronous, active low, clears all valid flags and queue pointers.
module uncertainty_propagation_alu_top #(
    parameter int QUEUE_DEPTH = upa_pkg::Q_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  upa_pkg::in_t  operands,
    output logic          done,
    output upa_pkg::out_t result
);
    import upa_pkg::*;

    logic take;
    logic fr_valid;
    job_t fr_item;
    logic q_valid;
    job_t q_item;
    logic q_full;

    assign take = start && !busy;
    assign busy = q_full;

    upa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .operands (operands),
        .valid    (fr_valid),
        .item     (fr_item)
    );

    upa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_valid),
        .push_item (fr_item),
        .pop       (q_valid),
        .valid     (q_valid),
        .item      (q_item),
        .full      (q_full)
    );

    upa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .item     (q_item),
        .done     (done),
        .result   (result)
    );

    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_DIV0 |-> result.r_value == '0 && result.r_unc == '0)
        else $error("divide by zero result not cleared");

    a_sqrt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_SQRT |-> result.r_value == '0 && result.r_unc == '0)
        else $error("non-positive root result not cleared");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid |=> !q_full)
        else $error("queue filled behind a free-running back end");

endmodule
